### rtl/hpa_pkg.sv
// shared constants, widths and types of the hex pixel to axial converter
`default_nettype none
package hpa_pkg;

  // field widths
  localparam int PIX_W = 24;
  localparam int INV_W = 17;
  localparam int AX_W  = 16;

  // default number of fraction bits of the pixel position
  localparam int FRAC_BITS_DEF = 8;

  // sqrt(3), unsigned with 20 fraction bits
  localparam int               SQ3_W   = 21;
  localparam logic [SQ3_W-1:0] SQ3_Q20 = 21'd1816187;

  // scaled products and their magnitudes
  localparam int NUM_W = 64;
  localparam int MAG_W = 63;

  // configuration port
  localparam int               PADDR_W      = 3;
  localparam int               PDATA_W      = 32;
  localparam logic             REG_INV_SIZE = 1'b0;
  localparam logic [INV_W-1:0] INV_RST      = 17'd2048;

  // pipeline layout: four scaling stages, four rounding stages, two select stages
  localparam int N_STAGES = 10;
  localparam int ST_SCALE = 0;
  localparam int ST_ROUND = 4;
  localparam int ST_PICK  = 8;

  typedef struct packed {
    logic [N_STAGES-1:0] en;
    logic [N_STAGES-1:0] vld;
  } hpa_pipe_t;

endpackage
`default_nettype wire

### rtl/hpa_pipe_ctrl.sv
// valid bits and per-stage load enables of the converter pipeline
`default_nettype none
module hpa_pipe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_ready_i,
  output hpa_pkg::hpa_pipe_t     pipe_o
);

  localparam int N = hpa_pkg::N_STAGES;

  logic [N-1:0] vld_q, vld_d;
  logic [N-1:0] en;

  // a stage loads when some stage at or after it is empty, or the output drains
  always_comb begin
    logic [N-1:0] low_mask;
    for (int i = 0; i < N; i++) begin
      low_mask = (N'(1) << i) - N'(1);
      en[i]    = out_ready_i || !(&(vld_q | low_mask));
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < N; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pipe_o.en  = en;
  assign pipe_o.vld = vld_q;

endmodule
`default_nettype wire

### rtl/hpa_scale.sv
// scaling stages: builds 3q, 3r and 3s on the common fixed-point scale
`default_nettype none
module hpa_scale (
  input  wire logic                                clk_i,
  input  wire logic [3:0]                          en_i,
  input  wire logic signed [hpa_pkg::PIX_W-1:0]    pixel_x_i,
  input  wire logic signed [hpa_pkg::PIX_W-1:0]    pixel_y_i,
  input  wire logic [hpa_pkg::INV_W-1:0]           inv_size_i,
  output logic signed [hpa_pkg::NUM_W-1:0]         nq_o,
  output logic signed [hpa_pkg::NUM_W-1:0]         nr_o,
  output logic signed [hpa_pkg::NUM_W-1:0]         ns_o
);

  localparam int PW = hpa_pkg::PIX_W;
  localparam int KW = hpa_pkg::INV_W + 1;
  localparam int XW = PW + hpa_pkg::SQ3_W + 1;
  localparam int YW = PW + KW;
  localparam int DW = XW + 1;
  localparam int NW = hpa_pkg::NUM_W;

  logic signed [KW-1:0]   k_s;
  logic signed [XW-1:0]   xs_d, xs_q;
  logic signed [YW-1:0]   yk_d, yk_q, yk2_q;
  logic signed [PW-1:0]   y_q;
  logic signed [DW-1:0]   dq_q;
  logic signed [DW+KW-1:0] nq_full;
  logic signed [NW-1:0]   nq_q, nr_q, nq4_q, nr4_q, ns4_q;
  logic signed [hpa_pkg::SQ3_W:0] sq3_w;

  assign k_s   = $signed({1'b0, inv_size_i});
  assign sq3_w = $signed({1'b0, hpa_pkg::SQ3_Q20});

  // stage 1: x * sqrt3 and y * k
  assign xs_d = pixel_x_i * sq3_w;
  assign yk_d = pixel_y_i * k_s;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xs_q <= xs_d;
      yk_q <= yk_d;
      y_q  <= pixel_y_i;
    end
  end

  // stage 2: x * sqrt3 - y * 2^20
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dq_q  <= DW'(xs_q) - (DW'(y_q) <<< 20);
      yk2_q <= yk_q;
    end
  end

  // stage 3: scale q by k, r is 2 * y * k * 2^20
  assign nq_full = dq_q * k_s;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      nq_q <= nq_full[NW-1:0];
      nr_q <= NW'(yk2_q) <<< 21;
    end
  end

  // stage 4: s closes the sum to zero
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      nq4_q <= nq_q;
      nr4_q <= nr_q;
      ns4_q <= -(nq_q + nr_q);
    end
  end

  assign nq_o = nq4_q;
  assign nr_o = nr4_q;
  assign ns_o = ns4_q;

endmodule
`default_nettype wire

### rtl/hpa_round.sv
// rounding stages: divides one scaled coordinate by 3 * 2^shift, half away from zero
`default_nettype none
module hpa_round #(
  parameter int FRAC_BITS = hpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic [3:0]                          en_i,
  input  wire logic signed [hpa_pkg::NUM_W-1:0]    num_i,
  output logic signed [hpa_pkg::MAG_W-FRAC_BITS-36:0] rnd_o,
  output logic [FRAC_BITS+36:0]                    err_o
);

  localparam int MW = hpa_pkg::MAG_W;
  localparam int NW = hpa_pkg::NUM_W;
  localparam int SH = FRAC_BITS + 36;
  localparam int TW = MW - SH;
  localparam longint unsigned RECIP_L = ((64'd1 << (TW + 1)) + 64'd2) / 64'd3;
  localparam logic [TW-1:0]   RECIP   = RECIP_L[TW-1:0];
  localparam logic [MW-1:0]   HALF    = {{(MW-2){1'b0}}, 2'b11} << (SH - 1);

  logic [NW-1:0]     abs_c;
  logic              sign5_q, sign6_q, sign7_q;
  logic [MW-1:0]     mag5_q, mag6_q, mag7_q;
  logic [MW-1:0]     sum6;
  logic [TW-1:0]     t6_q;
  logic [2*TW-1:0]   prod7;
  logic [TW-1:0]     qk7_q;
  logic [TW+1:0]     k3, ediff;
  logic signed [SH+2:0] e_c, eabs;
  logic signed [TW:0]   qk_s;
  logic signed [TW:0]   rnd_q;
  logic [SH:0]          err_q;

  // stage 5: sign and magnitude
  assign abs_c = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sign5_q <= num_i[NW-1];
      mag5_q  <= abs_c[MW-1:0];
    end
  end

  // stage 6: add half the divisor and drop the power of two
  assign sum6 = mag5_q + HALF;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sign6_q <= sign5_q;
      mag6_q  <= mag5_q;
      t6_q    <= sum6[MW-1:SH];
    end
  end

  // stage 7: divide by three through the reciprocal
  assign prod7 = t6_q * RECIP;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sign7_q <= sign6_q;
      mag7_q  <= mag6_q;
      qk7_q   <= TW'(prod7 >> (TW + 1));
    end
  end

  // stage 8: error = |mag - 3k * 2^shift|, only the top bits can differ by a few units
  assign k3    = {1'b0, qk7_q, 1'b0} + {2'b00, qk7_q};
  assign ediff = {2'b00, mag7_q[MW-1:SH]} - k3;
  assign e_c   = $signed({ediff[2:0], mag7_q[SH-1:0]});
  assign eabs  = e_c[SH+2] ? -e_c : e_c;
  assign qk_s  = $signed({1'b0, qk7_q});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      err_q <= eabs[SH:0];
      rnd_q <= sign7_q ? -qk_s : qk_s;
    end
  end

  assign rnd_o = rnd_q;
  assign err_o = err_q;

endmodule
`default_nettype wire

### rtl/hpa_pick.sv
// select stages: rebuilds the coordinate with the largest error and saturates
`default_nettype none
module hpa_pick #(
  parameter int FRAC_BITS = hpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic [1:0]                             en_i,
  input  wire logic signed [hpa_pkg::MAG_W-FRAC_BITS-36:0] rq_i,
  input  wire logic signed [hpa_pkg::MAG_W-FRAC_BITS-36:0] rr_i,
  input  wire logic signed [hpa_pkg::MAG_W-FRAC_BITS-36:0] rs_i,
  input  wire logic [FRAC_BITS+36:0]                  eq_i,
  input  wire logic [FRAC_BITS+36:0]                  er_i,
  input  wire logic [FRAC_BITS+36:0]                  es_i,
  output logic signed [hpa_pkg::AX_W-1:0]             axial_q_o,
  output logic signed [hpa_pkg::AX_W-1:0]             axial_r_o
);

  localparam int TW = hpa_pkg::MAG_W - FRAC_BITS - 36;
  localparam int AW = hpa_pkg::AX_W;
  localparam int RW = (TW + 2 > AW + 1) ? TW + 2 : AW + 1;
  localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (AW - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = -RW'(1 << (AW - 1));

  logic              pick_q9_q, pick_s9_q;
  logic signed [TW:0] rq9_q, rr9_q, rs9_q;
  logic signed [RW-1:0] qx, rx, sx, q_c, r_c;
  logic signed [AW-1:0] q_q, r_q;

  function automatic logic signed [AW-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [AW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[AW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[AW-1:0];
    end else begin
      res = v[AW-1:0];
    end
    return res;
  endfunction

  // stage 9: strict compares, ties fall to the later choice
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pick_q9_q <= (eq_i > es_i) && (eq_i > er_i);
      pick_s9_q <= es_i > er_i;
      rq9_q     <= rq_i;
      rr9_q     <= rr_i;
      rs9_q     <= rs_i;
    end
  end

  // stage 10: rebuild and saturate into the output register
  assign qx = RW'(rq9_q);
  assign rx = RW'(rr9_q);
  assign sx = RW'(rs9_q);

  always_comb begin
    q_c = qx;
    r_c = rx;
    priority if (pick_q9_q) begin
      q_c = -sx - rx;
    end else if (pick_s9_q) begin
      q_c = qx;
    end else begin
      r_c = -qx - sx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q_q <= sat(q_c);
      r_q <= sat(r_c);
    end
  end

  assign axial_q_o = q_q;
  assign axial_r_o = r_q;

endmodule
`default_nettype wire

### rtl/hex_pixel_to_axial_core.sv
// Maps a pixel position to the axial cell (q, r) of a pointy-top hex grid.
//
// Input stream: s_axis_tdata carries pixel_x and pixel_y, signed fixed point with
// FRAC_BITS fraction bits. Output stream: m_axis_tdata carries the rounded axial
// q and r, saturated to 16 bits signed. One result leaves for every input transfer,
// in order.
// The APB port holds one register, inv_hex_size at byte address 0, the reciprocal
// of the hex size with 16 fraction bits; it must be written by the user between
// items only, as the block does not enforce this. A transfer passes the stages
// on its way to m_axis: four of multiply and scale, four of rounding (divide by
// three through a reciprocal multiply), two of compare and rebuild. A new item is
// taken every cycle unless the pipeline is full and m_axis stalls. Each stage has
// its own valid bit and loads whenever it or a later stage has room, so a stalled
// receiver fills the pipeline before s_axis_tready falls, and bubbles are squeezed
// out; nothing is dropped or repeated. Reset empties the pipeline and sets inv_hex_size to 2048.
`default_nettype none
module hex_pixel_to_axial_core #(
  parameter int FRAC_BITS = hpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // apb configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hpa_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hpa_pkg::PDATA_W-1:0]   pwdata,
  output logic [hpa_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  // pixel stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [47:0]                   s_axis_tdata,  // pixel_x, pixel_y
  // cell stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata   // axial_q, axial_r
);

  localparam int PW = hpa_pkg::PIX_W;
  localparam int AW = hpa_pkg::AX_W;
  localparam int NW = hpa_pkg::NUM_W;
  localparam int SH = FRAC_BITS + 36;
  localparam int TW = hpa_pkg::MAG_W - SH;

  logic [hpa_pkg::INV_W-1:0] inv_size_q, inv_size_d;
  logic                      cfg_wr;
  logic                      reg_hit;
  hpa_pkg::hpa_pipe_t        pipe;

  logic signed [NW-1:0] nq, nr, ns;
  logic signed [TW:0]   rq, rr, rs;
  logic [SH:0]          eq, er, es;
  logic signed [AW-1:0] axial_q, axial_r;

  // configuration register
  assign reg_hit    = (paddr[2] == hpa_pkg::REG_INV_SIZE);
  assign cfg_wr     = psel && penable && pwrite && reg_hit;
  assign inv_size_d = cfg_wr ? pwdata[hpa_pkg::INV_W-1:0] : inv_size_q;
  assign pready     = 1'b1;
  assign prdata     = reg_hit ? hpa_pkg::PDATA_W'(inv_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_size_q <= hpa_pkg::INV_RST;
    end else begin
      inv_size_q <= inv_size_d;
    end
  end

  hpa_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pipe_o      (pipe)
  );

  assign s_axis_tready = pipe.en[0];
  assign m_axis_tvalid = pipe.vld[hpa_pkg::N_STAGES-1];

  hpa_scale u_scale (
    .clk_i      (clk_i),
    .en_i       (pipe.en[hpa_pkg::ST_SCALE +: 4]),
    .pixel_x_i  ($signed(s_axis_tdata[PW-1:0])),
    .pixel_y_i  ($signed(s_axis_tdata[2*PW-1:PW])),
    .inv_size_i (inv_size_q),
    .nq_o       (nq),
    .nr_o       (nr),
    .ns_o       (ns)
  );

  hpa_round #(.FRAC_BITS(FRAC_BITS)) u_round_q (
    .clk_i (clk_i),
    .en_i  (pipe.en[hpa_pkg::ST_ROUND +: 4]),
    .num_i (nq),
    .rnd_o (rq),
    .err_o (eq)
  );

  hpa_round #(.FRAC_BITS(FRAC_BITS)) u_round_r (
    .clk_i (clk_i),
    .en_i  (pipe.en[hpa_pkg::ST_ROUND +: 4]),
    .num_i (nr),
    .rnd_o (rr),
    .err_o (er)
  );

  hpa_round #(.FRAC_BITS(FRAC_BITS)) u_round_s (
    .clk_i (clk_i),
    .en_i  (pipe.en[hpa_pkg::ST_ROUND +: 4]),
    .num_i (ns),
    .rnd_o (rs),
    .err_o (es)
  );

  hpa_pick #(.FRAC_BITS(FRAC_BITS)) u_pick (
    .clk_i     (clk_i),
    .en_i      (pipe.en[hpa_pkg::ST_PICK +: 2]),
    .rq_i      (rq),
    .rr_i      (rr),
    .rs_i      (rs),
    .eq_i      (eq),
    .er_i      (er),
    .es_i      (es),
    .axial_q_o (axial_q),
    .axial_r_o (axial_r)
  );

  assign m_axis_tdata = {axial_r, axial_q};

`ifndef SYNTHESIS
  // an empty output stage never blocks the input side
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  // an input transfer always leaves an item somewhere in the pipeline
  a_transfer_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (|pipe.vld))
    else $error("input transfer lost");

  // an empty pipeline with no input cannot produce a result
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(|pipe.vld) && !s_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared from an empty pipeline");
`endif

endmodule
`default_nettype wire
